FILE: hdl/dle_frame_encoder_crc16_top_assert.svh
// Assertion macros used by the frame encoder back end.
`ifndef DLE_FRAME_ENCODER_CRC16_TOP_ASSERT_SVH
`define DLE_FRAME_ENCODER_CRC16_TOP_ASSERT_SVH

// Checked on every rising edge of clk, quiet while reset is asserted.
`define DFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define DFE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/dfe_pkg.sv
// Package: types, constants and CRC helper for the DLE frame encoder.
`default_nettype none
package dfe_pkg;

    localparam logic [7:0]  BYTE_DLE = 8'h10;
    localparam logic [7:0]  BYTE_STX = 8'h02;
    localparam logic [7:0]  BYTE_ETX = 8'h03;
    localparam logic [15:0] CRC_INIT = 16'h1D0F;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output steps of one command, in emission order
    localparam int          NUM_STEPS     = 10;
    localparam logic [3:0]  STEP_SOF_DLE  = 4'd0;
    localparam logic [3:0]  STEP_SOF_STX  = 4'd1;
    localparam logic [3:0]  STEP_BYTE_ESC = 4'd2;
    localparam logic [3:0]  STEP_BYTE     = 4'd3;
    localparam logic [3:0]  STEP_CRCH_ESC = 4'd4;
    localparam logic [3:0]  STEP_CRCH     = 4'd5;
    localparam logic [3:0]  STEP_CRCL_ESC = 4'd6;
    localparam logic [3:0]  STEP_CRCL     = 4'd7;
    localparam logic [3:0]  STEP_ETX_DLE  = 4'd8;
    localparam logic [3:0]  STEP_ETX      = 4'd9;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       empty_frame;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } result_t;

    // Classified work for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        has_sof;
        logic        has_byte;
        logic        has_tail;
        logic [15:0] crc;
    } cmd_t;

    // CRC-16 poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'b0, x[7:4]};
        return {crc[7:0], 8'b0} ^ {x[3:0], 12'b0} ^ {3'b0, x, 5'b0} ^ {8'b0, x};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/dfe_front.sv
// Front end: accepts input beats, runs the CRC and builds commands.
`default_nettype none
module dfe_front
    import dfe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t item,
    input  wire logic  q_full,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    assign cmd_push = push && !q_full;
    assign crc_base = item.first_of_frame ? CRC_INIT : crc_reg;

    always_comb
    begin
        if (item.empty_frame)
        begin
            crc_next     = CRC_INIT;
            cmd.has_sof  = 1'b1;
            cmd.has_byte = 1'b0;
            cmd.has_tail = 1'b1;
        end
        else
        begin
            crc_next     = crc_update(crc_base, item.payload_byte);
            cmd.has_sof  = item.first_of_frame;
            cmd.has_byte = 1'b1;
            cmd.has_tail = item.last_of_frame;
        end
        cmd.data = item.payload_byte;
        cmd.crc  = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else if (cmd_push)
            crc_reg <= crc_next;
    end

endmodule
`default_nettype wire

FILE: hdl/dfe_cmd_queue.sv
// Command queue between front and back ends.
`default_nettype none
module dfe_cmd_queue
    import dfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      q_full,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      q_empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/dfe_back.sv
// Back end: commands into stuffed frame bytes, at most one per cycle.
`default_nettype none
module dfe_back
    import dfe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic q_empty,
    output logic      q_pop,
    output result_t   result,
    output logic      empty,
    input  wire logic pop
);

    `include "dle_frame_encoder_crc16_top_assert.svh"

    logic [3:0]           phase_reg;
    logic [3:0]           phase_next;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              out_next;
    logic [NUM_STEPS-1:0] mask;
    logic [NUM_STEPS-1:0] remaining;
    logic [3:0]           sel;
    logic                 more;
    logic                 fire;

    always_comb
    begin
        mask[STEP_SOF_DLE]  = head.has_sof;
        mask[STEP_SOF_STX]  = head.has_sof;
        mask[STEP_BYTE_ESC] = head.has_byte && (head.data == BYTE_DLE);
        mask[STEP_BYTE]     = head.has_byte;
        mask[STEP_CRCH_ESC] = head.has_tail && (head.crc[15:8] == BYTE_DLE);
        mask[STEP_CRCH]     = head.has_tail;
        mask[STEP_CRCL_ESC] = head.has_tail && (head.crc[7:0] == BYTE_DLE);
        mask[STEP_CRCL]     = head.has_tail;
        mask[STEP_ETX_DLE]  = head.has_tail;
        mask[STEP_ETX]      = head.has_tail;
    end

    // lowest step still pending, and whether any follows it
    always_comb
    begin
        for (int i = 0; i < NUM_STEPS; i++)
            remaining[i] = mask[i] && (4'(i) >= phase_reg);
        sel = STEP_ETX;
        for (int i = NUM_STEPS - 1; i >= 0; i--)
            if (remaining[i])
                sel = 4'(i);
        more = 1'b0;
        for (int i = 0; i < NUM_STEPS; i++)
            if (remaining[i] && (4'(i) > sel))
                more = 1'b1;
    end

    always_comb
    begin
        case (sel)
            STEP_SOF_DLE:  out_next.out_byte = BYTE_DLE;
            STEP_SOF_STX:  out_next.out_byte = BYTE_STX;
            STEP_BYTE_ESC: out_next.out_byte = BYTE_DLE;
            STEP_BYTE:     out_next.out_byte = head.data;
            STEP_CRCH_ESC: out_next.out_byte = BYTE_DLE;
            STEP_CRCH:     out_next.out_byte = head.crc[15:8];
            STEP_CRCL_ESC: out_next.out_byte = BYTE_DLE;
            STEP_CRCL:     out_next.out_byte = head.crc[7:0];
            STEP_ETX_DLE:  out_next.out_byte = BYTE_DLE;
            STEP_ETX:      out_next.out_byte = BYTE_ETX;
            default:       out_next.out_byte = BYTE_ETX;
        endcase
        out_next.last_of_run = !more;
        out_next.frame_end   = (sel == STEP_ETX);
    end

    assign fire       = !q_empty && (!out_valid_reg || pop);
    assign q_pop      = fire && !more;
    assign phase_next = more ? sel + 1'b1 : 4'd0;
    assign result     = out_reg;
    assign empty      = !out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
                phase_reg <= phase_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    `DFE_ASSERT(a_phase_range, phase_reg <= STEP_ETX, "step counter out of range")
    `DFE_ASSERT(a_pop_nonempty, q_pop |-> !q_empty, "command popped from empty queue")
    `DFE_ASSERT(a_end_is_last, (out_valid_reg && out_reg.frame_end) |-> out_reg.last_of_run,
        "frame end byte not flagged as last of run")
    `DFE_ASSERT(a_phase_idle, (fire && !more) |=> (phase_reg == 4'd0),
        "step counter not rewound after command")

endmodule
`default_nettype wire

FILE: hdl/dle_frame_encoder_crc16_top.sv
// Top level of the DLE/STX/ETX frame encoder with CRC-16.
`default_nettype none
// Payload bytes enter as queue pushes and leave as a byte-stuffed frame:
// DLE STX on a first byte, each byte with DLE doubled, and on a last byte
// the CRC-16 (poly 0x1021, init 0x1D0F) high then low, stuffed, then
// DLE ETX. The front end takes one input beat per cycle into a four-entry
// command queue; the back end sends one output byte per cycle while the
// output is free or popped, and an item yields 1 to 10 bytes (0 to 2 for
// the byte, 2 more with a first mark, 4 to 6 more for the tail). Sustained
// rate is set by that byte count; pushes stall only when the queue is full.
module dle_frame_encoder_crc16_top
    import dfe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire item_t   item,
    output logic         full,
    output result_t      result,
    output logic         empty,
    input  wire logic    pop
);

    logic cmd_push;
    cmd_t cmd;
    cmd_t head;
    logic q_empty;
    logic q_pop;

    dfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_full   (full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    dfe_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd),
        .q_full  (full),
        .rd_en   (q_pop),
        .rd_cmd  (head),
        .q_empty (q_empty)
    );

    dfe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
`default_nettype wire
